@@ sv/wts_pkg.sv @@
// Shared types and constants for the world-to-screen projection block.
package wts_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int COORD_W   = 32;
  localparam int Q_W       = 32;

  localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic vis;
    logic ovx;
    logic ovy;
    logic negx;
    logic negy;
  } wts_tag_t;

endpackage

@@ sv/world_to_screen_projection.sv @@
// Top level of the world-to-screen projection block.
// Each input word on in_ carries one world point (x, y, z in signed fixed point).
// The point goes through a 4x4 matrix loaded on the cfg_ port, is tested against
// a minimum clip w, divided by w and mapped to the screen range.
// Each input word gives exactly one output word on out_, in order.
// out_tuser is high when the point is visible; otherwise both coordinates are zero.
// From acceptance to out_tvalid a word passes one multiply stage, one sum stage,
// one setup stage, 32 divider stages (one quotient bit each), one scaling
// multiply stage and one saturation stage that is the output register.
// One word per cycle unless out_tready stalls; the divider stages set the latency.
// Each stage holds its own valid bit, so when out_tready is low the pipeline
// keeps filling its empty stages and only stops accepting once all are full.
// Reset clears all valid bits and loads the matrix with its identity values.
// User must write matrix registers only while no word is in flight (not enforced).
module world_to_screen_projection import wts_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,   // point_x, point_y, point_z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // screen_x, screen_y
  output logic                 out_tuser,  // visible
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int CLIP_W = 67 - FRACTION_BITS;
  localparam int DIV_W  = CLIP_W - 1;
  localparam int SH_UP  = 32 - FRACTION_BITS;
  localparam logic signed [CLIP_W-1:0] W_MIN =
    CLIP_W'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
  localparam int KX = 33 + $clog2(SCREEN_WIDTH);
  localparam int KY = 33 + $clog2(SCREEN_HEIGHT);
  localparam logic [63:0] MX =
    ((64'd1 << KX) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);
  localparam logic [63:0] MY =
    ((64'd1 << KY) + 64'(SCREEN_HEIGHT) - 64'd1) / 64'(SCREEN_HEIGHT);
  localparam logic [17:0] MXL = MX[17:0];
  localparam logic [16:0] MXH = MX[34:18];
  localparam logic [17:0] MYL = MY[17:0];
  localparam logic [16:0] MYH = MY[34:18];

  logic [REG_W-1:0] mat_r [NUM_REGS];
  logic signed [COORD_W-1:0] ent [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) mat_r[i] <= MAT_RESET[i];
    end else if (cfg_we) begin
      mat_r[cfg_addr] <= cfg_wdata;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_ent
    if (k % 2 == 1) begin : g_hi
      assign ent[k] = signed'(mat_r[k/2][63:32]);
    end else begin : g_lo
      assign ent[k] = signed'(mat_r[k/2][31:0]);
    end
  end

  // Stage 1: nine products.
  logic signed [COORD_W-1:0] pt [3];
  logic signed [63:0] prod_r [3][3];
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic div_s_ready, div_m_valid;

  assign pt[0] = signed'(in_tdata[31:0]);
  assign pt[1] = signed'(in_tdata[63:32]);
  assign pt[2] = signed'(in_tdata[95:64]);

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || div_s_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= div_m_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[0][i] <= pt[i] * ent[4*i];
        prod_r[1][i] <= pt[i] * ent[4*i+1];
        prod_r[2][i] <= pt[i] * ent[4*i+3];
      end
    end
  end

  // Stage 2: clip x, y and w.
  localparam int TRANS [3] = '{12, 13, 15};
  logic signed [CLIP_W-1:0] clip_nxt [3];
  logic signed [CLIP_W-1:0] clip_r [3];

  always_comb begin
    logic signed [65:0] sum;
    logic signed [65:0] sh;
    for (int r = 0; r < 3; r++) begin
      sum = 66'(prod_r[r][0]) + 66'(prod_r[r][1]) + 66'(prod_r[r][2]);
      sh  = sum >>> FRACTION_BITS;
      clip_nxt[r] = CLIP_W'(sh) + CLIP_W'(ent[TRANS[r]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int r = 0; r < 3; r++) clip_r[r] <= clip_nxt[r];
    end
  end

  // Stage 3: visibility, magnitudes, overflow tests, divider setup.
  logic [CLIP_W-1:0] magx, magy;
  logic [DIV_W-1:0]  wv;
  logic [CLIP_W+31:0] wlim;
  wts_tag_t          tag_nxt, tag3_r;
  logic [DIV_W-1:0]  w3_r, rx3_r, ry3_r;
  logic [Q_W-1:0]    dx3_r, dy3_r;

  always_comb begin
    magx = clip_r[0][CLIP_W-1] ? CLIP_W'(-clip_r[0]) : CLIP_W'(clip_r[0]);
    magy = clip_r[1][CLIP_W-1] ? CLIP_W'(-clip_r[1]) : CLIP_W'(clip_r[1]);
    wv   = clip_r[2][DIV_W-1:0];
    wlim = (CLIP_W+32)'(wv) << SH_UP;
    tag_nxt.vis  = (clip_r[2] >= W_MIN);
    tag_nxt.ovx  = ((CLIP_W+32)'(magx) >= wlim);
    tag_nxt.ovy  = ((CLIP_W+32)'(magy) >= wlim);
    tag_nxt.negx = clip_r[0][CLIP_W-1];
    tag_nxt.negy = clip_r[1][CLIP_W-1];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      tag3_r <= tag_nxt;
      w3_r   <= wv;
      rx3_r  <= DIV_W'(magx >> SH_UP);
      ry3_r  <= DIV_W'(magy >> SH_UP);
      dx3_r  <= 32'(magx << FRACTION_BITS);
      dy3_r  <= 32'(magy << FRACTION_BITS);
    end
  end

  logic [Q_W-1:0] qx, qy;
  wts_tag_t       tagd;

  wts_div #(.DIV_W(DIV_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v3_r),
    .s_ready (div_s_ready),
    .s_w     (w3_r),
    .s_rx    (rx3_r),
    .s_dx    (dx3_r),
    .s_ry    (ry3_r),
    .s_dy    (dy3_r),
    .s_tag   (tag3_r),
    .m_valid (div_m_valid),
    .m_ready (rdy4),
    .m_qx    (qx),
    .m_qy    (qy),
    .m_tag   (tagd)
  );

  // Stage 4: reciprocal partial products for 2q / size.
  logic [50:0] plx_r, ply_r;
  logic [49:0] phx_r, phy_r;
  logic [Q_W-1:0] qx4_r, qy4_r;
  wts_tag_t tag4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      plx_r  <= {qx, 1'b0} * MXL;
      phx_r  <= {qx, 1'b0} * MXH;
      ply_r  <= {qy, 1'b0} * MYL;
      phy_r  <= {qy, 1'b0} * MYH;
      qx4_r  <= qx;
      qy4_r  <= qy;
      tag4_r <= tagd;
    end
  end

  // Stage 5: scale, sign and saturate.
  function automatic logic [31:0] sat_out(input logic ov, input logic neg,
                                          input logic [33:0] t_in);
    logic [33:0] t;
    logic [31:0] res;
    t = ov ? 34'h1_0000_0000 : t_in;
    if (neg) begin
      res = (t >= 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-t);
    end else begin
      res = (t > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : t[31:0];
    end
    return res;
  endfunction

  logic [67:0] sumx, sumy;
  logic [33:0] tx, ty;
  logic [31:0] sx_nxt, sy_nxt;
  logic [63:0] data5_r;
  logic        vis5_r;

  always_comb begin
    sumx = (68'(phx_r) << 18) + 68'(plx_r);
    sumy = (68'(phy_r) << 18) + 68'(ply_r);
    tx = 34'(qx4_r) + 34'(sumx >> KX);
    ty = 34'(qy4_r) + 34'(sumy >> KY);
    sx_nxt = tag4_r.vis ? sat_out(tag4_r.ovx, tag4_r.negx, tx) : '0;
    sy_nxt = tag4_r.vis ? sat_out(tag4_r.ovy, tag4_r.negy, ty) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      data5_r <= {sy_nxt, sx_nxt};
      vis5_r  <= tag4_r.vis;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = data5_r;
  assign out_tuser  = vis5_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 64'd0)
    else $error("hidden point with nonzero coordinates");
  a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("input stalled with empty first stage");
  a_div_drain: assert property (@(posedge clk) disable iff (!rst_n)
    div_m_valid && rdy4 && !v3_r |=> div_s_ready)
    else $error("divider not ready after draining");

endmodule

@@ sv/wts_div.sv @@
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module wts_div import wts_pkg::*; #(
  parameter int DIV_W = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [DIV_W-1:0] s_w,
  input  logic [DIV_W-1:0] s_rx,
  input  logic [Q_W-1:0]   s_dx,
  input  logic [DIV_W-1:0] s_ry,
  input  logic [Q_W-1:0]   s_dy,
  input  wts_tag_t         s_tag,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [Q_W-1:0]   m_qx,
  output logic [Q_W-1:0]   m_qy,
  output wts_tag_t         m_tag
);

  logic             vld_a [0:Q_W];
  logic [DIV_W-1:0] w_a   [0:Q_W-1];
  logic [DIV_W-1:0] rx_a  [0:Q_W-1];
  logic [DIV_W-1:0] ry_a  [0:Q_W-1];
  logic [Q_W-1:0]   dx_a  [0:Q_W];
  logic [Q_W-1:0]   dy_a  [0:Q_W];
  wts_tag_t         tag_a [0:Q_W];
  logic             rdy   [1:Q_W+1];

  assign vld_a[0] = s_valid;
  assign w_a[0]   = s_w;
  assign rx_a[0]  = s_rx;
  assign ry_a[0]  = s_ry;
  assign dx_a[0]  = s_dx;
  assign dy_a[0]  = s_dy;
  assign tag_a[0] = s_tag;
  assign rdy[Q_W+1] = m_ready;
  assign s_ready  = rdy[1];

  for (genvar j = 1; j <= Q_W; j++) begin : g_stage
    logic             vld_r;
    logic [Q_W-1:0]   dx_r;
    logic [Q_W-1:0]   dy_r;
    wts_tag_t         tag_r;
    logic [DIV_W:0]   tx;
    logic [DIV_W:0]   ty;
    logic             gx;
    logic             gy;

    always_comb begin
      tx = {rx_a[j-1], dx_a[j-1][Q_W-1]};
      ty = {ry_a[j-1], dy_a[j-1][Q_W-1]};
      gx = (tx >= {1'b0, w_a[j-1]});
      gy = (ty >= {1'b0, w_a[j-1]});
    end

    assign rdy[j] = !vld_r || rdy[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[j]) begin
        vld_r <= vld_a[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        dx_r  <= {dx_a[j-1][Q_W-2:0], gx};
        dy_r  <= {dy_a[j-1][Q_W-2:0], gy};
        tag_r <= tag_a[j-1];
      end
    end

    assign vld_a[j] = vld_r;
    assign dx_a[j]  = dx_r;
    assign dy_a[j]  = dy_r;
    assign tag_a[j] = tag_r;

    if (j < Q_W) begin : g_rem
      logic [DIV_W-1:0] w_r;
      logic [DIV_W-1:0] rx_r;
      logic [DIV_W-1:0] ry_r;
      logic [DIV_W-1:0] rx_nxt;
      logic [DIV_W-1:0] ry_nxt;
      always_comb begin
        rx_nxt = gx ? DIV_W'(tx - {1'b0, w_a[j-1]}) : tx[DIV_W-1:0];
        ry_nxt = gy ? DIV_W'(ty - {1'b0, w_a[j-1]}) : ty[DIV_W-1:0];
      end
      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          w_r  <= w_a[j-1];
          rx_r <= rx_nxt;
          ry_r <= ry_nxt;
        end
      end
      assign w_a[j]  = w_r;
      assign rx_a[j] = rx_r;
      assign ry_a[j] = ry_r;
    end
  end

  assign m_valid = vld_a[Q_W];
  assign m_qx    = dx_a[Q_W];
  assign m_qy    = dy_a[Q_W];
  assign m_tag   = tag_a[Q_W];

endmodule
